@@ rtl/stp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg
// shared types and constants of the trapezoidal step-rate profile generator
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int RATE_W   = 24;
    localparam int RAMP_W   = 16;
    localparam int CRUISE_W = 32;
    localparam int MINR_W   = 16;
    localparam int INC_W    = 8;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    typedef enum logic {
        KIND_MOVE = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        REG_RAMP_STEPS     = 2'd0,
        REG_MIN_RATE       = 2'd1,
        REG_RATE_INCREMENT = 2'd2,
        REG_NONE           = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [RAMP_W-1:0] ramp_steps;
        logic [MINR_W-1:0] min_rate;
        logic [INC_W-1:0]  rate_increment;
    } t_cfg;

    typedef struct packed {
        logic [RAMP_W-1:0]   accel_left;
        logic [CRUISE_W-1:0] cruise_left;
        logic [RAMP_W-1:0]   decel_left;
        logic [RATE_W-1:0]   rate;
        logic                dir_ccw;
    } t_motion;

    typedef struct packed {
        logic              rejected;
        logic              stopped;
        logic [RATE_W-1:0] step_rate;
        logic [31:0]       position;
        logic              direction_ccw;
        logic              step_pulse;
    } t_result;

    function automatic logic motion_idle(input t_motion m);
        return (m.accel_left == '0) && (m.cruise_left == '0) && (m.decel_left == '0);
    endfunction

endpackage

@@ rtl/stp_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_cfg_regs
// apb register file for ramp length, start rate and rate increment
// ----------------------------------------------------------------------------
module stp_cfg_regs
    import stp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_RAMP_STEPS:     n_cfg.ramp_steps     = pwdata[RAMP_W-1:0];
                REG_MIN_RATE:       n_cfg.min_rate       = pwdata[MINR_W-1:0];
                REG_RATE_INCREMENT: n_cfg.rate_increment = pwdata[INC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RAMP_STEPS:     prdata = APB_DW'(r_cfg.ramp_steps);
            REG_MIN_RATE:       prdata = APB_DW'(r_cfg.min_rate);
            REG_RATE_INCREMENT: prdata = APB_DW'(r_cfg.rate_increment);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_steps     <= RAMP_W'(200);
            r_cfg.min_rate       <= MINR_W'(100);
            r_cfg.rate_increment <= INC_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/stp_move_plan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_move_plan
// splits a move distance into accelerate, cruise and decelerate counts
// ----------------------------------------------------------------------------
module stp_move_plan
    import stp_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  logic signed [31:0]          i_target,
    input  logic signed [POS_WIDTH-1:0] i_pos,
    input  t_cfg                        i_cfg,
    output logic                        o_moves,
    output t_motion                     o_mot
);

    localparam int EW = (POS_WIDTH > 32) ? POS_WIDTH : 32;
    localparam logic [EW-1:0] CRUISE_MAX = EW'(64'hFFFF_FFFF);

    logic signed [EW:0] tgt_x;
    logic signed [EW:0] pos_x;
    logic signed [EW:0] diff_fwd;
    logic signed [EW:0] diff_rev;
    logic [EW-1:0]      move_len;
    logic [EW-1:0]      twice;
    logic [EW-1:0]      cruise_long;
    logic               short_move;

    assign tgt_x    = (EW+1)'(i_target);
    assign pos_x    = (EW+1)'(i_pos);
    assign diff_fwd = tgt_x - pos_x;
    assign diff_rev = pos_x - tgt_x;
    assign move_len = diff_fwd[EW] ? diff_rev[EW-1:0] : diff_fwd[EW-1:0];
    assign o_moves  = (diff_fwd != '0);

    assign twice       = EW'({i_cfg.ramp_steps, 1'b0});
    assign short_move  = (move_len <= twice);
    assign cruise_long = move_len - twice;

    always_comb begin
        o_mot.dir_ccw = diff_fwd[EW];
        o_mot.rate    = RATE_W'(i_cfg.min_rate);
        if (short_move) begin
            o_mot.accel_left  = move_len[RAMP_W:1];
            o_mot.decel_left  = move_len[RAMP_W:1];
            o_mot.cruise_left = CRUISE_W'(move_len[0]);
        end else begin
            o_mot.accel_left  = i_cfg.ramp_steps;
            o_mot.decel_left  = i_cfg.ramp_steps;
            o_mot.cruise_left = (cruise_long > CRUISE_MAX) ? {CRUISE_W{1'b1}}
                                                           : cruise_long[CRUISE_W-1:0];
        end
    end

endmodule

@@ rtl/stp_tick_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_tick_step
// one step-timer tick: phase countdown, position advance and rate ramp
// ----------------------------------------------------------------------------
module stp_tick_step
    import stp_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  t_motion                     i_mot,
    input  logic signed [POS_WIDTH-1:0] i_pos,
    input  logic [INC_W-1:0]            i_inc,
    output logic                        o_step,
    output t_motion                     o_mot,
    output logic signed [POS_WIDTH-1:0] o_pos
);

    logic [RATE_W:0]   rate_up;
    logic [RATE_W-1:0] inc_x;
    logic [RATE_W-1:0] rate_acc;
    logic [RATE_W-1:0] rate_dec;
    logic signed [POS_WIDTH-1:0] pos_adv;

    assign inc_x    = RATE_W'(i_inc);
    assign rate_up  = {1'b0, i_mot.rate} + {1'b0, inc_x};
    assign rate_acc = rate_up[RATE_W] ? RATE_MAX : rate_up[RATE_W-1:0];
    assign rate_dec = (i_mot.rate >= inc_x) ? (i_mot.rate - inc_x) : '0;
    assign pos_adv  = i_mot.dir_ccw ? (i_pos - POS_WIDTH'(1)) : (i_pos + POS_WIDTH'(1));

    always_comb begin
        o_mot  = i_mot;
        o_pos  = i_pos;
        o_step = 1'b1;
        priority if (i_mot.accel_left != '0) begin
            o_pos            = pos_adv;
            o_mot.rate       = rate_acc;
            o_mot.accel_left = i_mot.accel_left - RAMP_W'(1);
        end else if (i_mot.cruise_left != '0) begin
            o_pos             = pos_adv;
            o_mot.cruise_left = i_mot.cruise_left - CRUISE_W'(1);
        end else if (i_mot.decel_left != '0) begin
            o_pos            = pos_adv;
            o_mot.rate       = rate_dec;
            o_mot.decel_left = i_mot.decel_left - RAMP_W'(1);
        end else begin
            o_step = 1'b0;
        end
    end

endmodule

@@ rtl/stepper_trapezoid_profile_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_trapezoid_profile_core
// trapezoidal step-rate profile generator: move commands and step ticks in,
// one status word out per item
//
//   channel   dir   handshake             content
//   s_axis    in    tvalid/tready         tuser kind, tdata target_position
//   m_axis    out   tvalid/tready         tdata status word
//   apb       in    psel/penable/pwrite   ramp_steps, min_rate, rate_increment
//
// one word per cycle sustained while m_axis is not stalled; input register,
// then planner/tick logic into the state and output registers
// the input register refills while the output register waits, so a stalled
// m_axis holds at most two words inside the block
// synchronous active-low reset clears state and loads register defaults
// ----------------------------------------------------------------------------
module stepper_trapezoid_profile_core
    import stp_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [31:0]       i_s_axis_tdata,   // target_position[31:0]
    input  logic              i_s_axis_tuser,   // kind[0]
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // step_pulse[0], direction_ccw[1], position[33:2], step_rate[57:34],
    // stopped[58], rejected[59], zero[63:60]
    output logic [63:0]       o_m_axis_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int EW = (POS_WIDTH > 32) ? POS_WIDTH : 32;

    t_cfg cfg;

    logic               r_in_valid;
    t_kind              r_in_kind;
    logic signed [31:0] r_in_target;

    t_motion                     r_mot;
    t_motion                     n_mot;
    logic signed [POS_WIDTH-1:0] r_pos;
    logic signed [POS_WIDTH-1:0] n_pos;

    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic    advance;
    logic    plan_moves;
    t_motion plan_mot;
    logic    tick_step;
    t_motion tick_mot;
    logic signed [POS_WIDTH-1:0] tick_pos;
    logic    step_pulse;
    logic    rejected;
    logic signed [EW-1:0] pos_x;

    stp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    stp_move_plan #(.POS_WIDTH(POS_WIDTH)) u_plan (
        .i_target (r_in_target),
        .i_pos    (r_pos),
        .i_cfg    (cfg),
        .o_moves  (plan_moves),
        .o_mot    (plan_mot)
    );

    stp_tick_step #(.POS_WIDTH(POS_WIDTH)) u_tick (
        .i_mot  (r_mot),
        .i_pos  (r_pos),
        .i_inc  (cfg.rate_increment),
        .o_step (tick_step),
        .o_mot  (tick_mot),
        .o_pos  (tick_pos)
    );

    assign advance         = r_in_valid & (~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = 64'(r_out);

    always_comb begin
        n_mot      = r_mot;
        n_pos      = r_pos;
        step_pulse = 1'b0;
        rejected   = 1'b0;
        unique case (r_in_kind)
            KIND_MOVE: begin
                if (!motion_idle(r_mot)) begin
                    rejected = 1'b1;
                end else if (plan_moves) begin
                    n_mot = plan_mot;
                end
            end
            KIND_TICK: begin
                n_mot      = tick_mot;
                n_pos      = tick_pos;
                step_pulse = tick_step;
            end
            default: ;
        endcase
    end

    assign pos_x = EW'(n_pos);

    always_comb begin
        n_out.step_pulse    = step_pulse;
        n_out.direction_ccw = n_mot.dir_ccw;
        n_out.position      = pos_x[31:0];
        n_out.step_rate     = n_mot.rate;
        n_out.stopped       = motion_idle(n_mot);
        n_out.rejected      = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mot       <= '0;
            r_pos       <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mot       <= n_mot;
                r_pos       <= n_pos;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_kind   <= t_kind'(i_s_axis_tuser);
            r_in_target <= i_s_axis_tdata;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
